[hdl/gcc_pkg.sv]
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared constants and controller/datapath interface types for the grid
// component counter.
// ----------------------------------------------------------------------------
package gcc_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int POS_W       = IDX_W + 1;
    localparam int SIZE_W      = 7;
    localparam int COUNT_W     = 12;

    // neighbour directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_WRAP = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0] rows;
        logic [SIZE_W-1:0] cols;
        logic              wrap;
    } gcc_cfg_t;

    typedef struct packed {
        logic load_we;
        logic scan_start;
        logic scan_rd;
        logic scan_adv;
        logic piece_start;
        logic pop_rd;
        logic pop_take;
        logic nb_calc;
        logic nb_rd;
        logic nb_hit;
        logic nb_adv;
        logic result_load;
    } gcc_cmd_t;

    typedef struct packed {
        logic last_cell;
        logic cell_bit;
        logic scan_last;
        logic queue_empty;
        logic nb_ok;
        logic nb_last;
        logic out_busy;
    } gcc_status_t;

endpackage

[hdl/gcc_datapath.sv]
// ----------------------------------------------------------------------------
// gcc_datapath
// Cell store, frontier queue, scan/load counters and the piece counter.
// ----------------------------------------------------------------------------
module gcc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gcc_pkg::gcc_cfg_t    cfg,
    input  gcc_pkg::gcc_cmd_t    cmd,
    input  logic                 cell_value,
    input  logic                 out_taken,
    output gcc_pkg::gcc_status_t status,
    output logic                 out_valid,
    output logic [11:0]          piece_count
);
    import gcc_pkg::*;

    logic                 cell_mem [STORE_DEPTH];
    logic [IDX_W-1:0]     queue_mem [STORE_DEPTH];

    logic                 cell_rd_reg;
    logic [IDX_W-1:0]     queue_rd_reg;
    logic [POS_W-1:0]     load_pos_reg;
    logic [POS_W-1:0]     scan_pos_reg;
    logic [ROW_W-1:0]     scan_r_reg;
    logic [COL_W-1:0]     scan_c_reg;
    logic [POS_W-1:0]     head_reg;
    logic [POS_W-1:0]     tail_reg;
    logic [ROW_W-1:0]     cur_r_reg;
    logic [COL_W-1:0]     cur_c_reg;
    logic [1:0]           dir_reg;
    logic                 nb_ok_reg;
    logic [ROW_W-1:0]     nb_r_reg;
    logic [COL_W-1:0]     nb_c_reg;
    logic [IDX_W-1:0]     nb_idx_reg;
    logic [COUNT_W-1:0]   pieces_reg;
    logic                 out_valid_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    logic [SIZE_W-1:0]    rows;
    logic [SIZE_W-1:0]    cols;
    logic [2*SIZE_W-1:0]  total_full;
    logic [POS_W-1:0]     total;
    logic [POS_W-1:0]     load_pos_inc;
    logic [POS_W-1:0]     scan_pos_inc;

    logic                 nb_ok_next;
    logic [ROW_W-1:0]     nb_r_next;
    logic [COL_W-1:0]     nb_c_next;
    logic [2*SIZE_W-1:0]  nb_idx_full;

    logic                 cell_we;
    logic [IDX_W-1:0]     cell_waddr;
    logic                 cell_wdata;
    logic [IDX_W-1:0]     cell_raddr;
    logic                 queue_we;
    logic [IDX_W-1:0]     queue_waddr;
    logic [IDX_W-1:0]     queue_wdata;

    // clamp sizes: zero acts as one, above the maximum acts as the maximum
    always_comb
    begin
        rows = cfg.rows;
        if (cfg.rows == '0)
            rows = SIZE_W'(1);
        else if (cfg.rows > SIZE_W'(MAX_ROWS))
            rows = SIZE_W'(MAX_ROWS);
        cols = cfg.cols;
        if (cfg.cols == '0)
            cols = SIZE_W'(1);
        else if (cfg.cols > SIZE_W'(MAX_COLS))
            cols = SIZE_W'(MAX_COLS);
    end

    assign total_full   = {{SIZE_W{1'b0}}, rows} * {{SIZE_W{1'b0}}, cols};
    assign total        = total_full[POS_W-1:0];
    assign load_pos_inc = load_pos_reg + POS_W'(1);
    assign scan_pos_inc = scan_pos_reg + POS_W'(1);

    // neighbour of the current cell in direction dir_reg
    always_comb
    begin
        nb_ok_next = 1'b0;
        nb_r_next  = cur_r_reg;
        nb_c_next  = cur_c_reg;
        case (dir_reg)
            DIR_UP:
            begin
                nb_ok_next = (cur_r_reg != '0);
                nb_r_next  = cur_r_reg - ROW_W'(1);
            end
            DIR_DOWN:
            begin
                nb_ok_next = ({1'b0, cur_r_reg} + SIZE_W'(1)) < rows;
                nb_r_next  = cur_r_reg + ROW_W'(1);
            end
            DIR_LEFT:
            begin
                if (cur_c_reg != '0)
                begin
                    nb_ok_next = 1'b1;
                    nb_c_next  = cur_c_reg - COL_W'(1);
                end
                else
                begin
                    nb_ok_next = cfg.wrap;
                    nb_c_next  = COL_W'(cols - SIZE_W'(1));
                end
            end
            default:
            begin
                if (({1'b0, cur_c_reg} + SIZE_W'(1)) < cols)
                begin
                    nb_ok_next = 1'b1;
                    nb_c_next  = cur_c_reg + COL_W'(1);
                end
                else
                begin
                    nb_ok_next = cfg.wrap;
                    nb_c_next  = '0;
                end
            end
        endcase
    end

    assign nb_idx_full = {{(2*SIZE_W-ROW_W){1'b0}}, nb_r_next} * {{SIZE_W{1'b0}}, cols}
                       + {{(2*SIZE_W-COL_W){1'b0}}, nb_c_next};

    // memory port selection
    always_comb
    begin
        cell_we     = 1'b0;
        cell_waddr  = nb_idx_reg;
        cell_wdata  = 1'b0;
        if (cmd.load_we)
        begin
            cell_we    = (load_pos_reg < POS_W'(STORE_DEPTH));
            cell_waddr = load_pos_reg[IDX_W-1:0];
            cell_wdata = cell_value;
        end
        else if (cmd.piece_start)
        begin
            cell_we    = 1'b1;
            cell_waddr = scan_pos_reg[IDX_W-1:0];
        end
        else if (cmd.nb_hit)
        begin
            cell_we = 1'b1;
        end
        cell_raddr = cmd.scan_rd ? scan_pos_reg[IDX_W-1:0] : nb_idx_reg;

        queue_we    = 1'b0;
        queue_waddr = tail_reg[IDX_W-1:0];
        queue_wdata = {nb_r_reg, nb_c_reg};
        if (cmd.piece_start)
        begin
            queue_we    = 1'b1;
            queue_waddr = '0;
            queue_wdata = {scan_r_reg, scan_c_reg};
        end
        else if (cmd.nb_hit)
        begin
            queue_we = (tail_reg < POS_W'(STORE_DEPTH));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[cell_waddr] <= cell_wdata;
        if (cmd.scan_rd || cmd.nb_rd)
            cell_rd_reg <= cell_mem[cell_raddr];
        if (queue_we)
            queue_mem[queue_waddr] <= queue_wdata;
        if (cmd.pop_rd)
            queue_rd_reg <= queue_mem[head_reg[IDX_W-1:0]];
        if (cmd.nb_calc)
        begin
            nb_r_reg   <= nb_r_next;
            nb_c_reg   <= nb_c_next;
            nb_idx_reg <= nb_idx_full[IDX_W-1:0];
        end
        if (cmd.pop_take)
        begin
            cur_r_reg <= queue_rd_reg[IDX_W-1:COL_W];
            cur_c_reg <= queue_rd_reg[COL_W-1:0];
        end
        if (cmd.result_load)
            out_count_reg <= pieces_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg  <= '0;
            scan_pos_reg  <= '0;
            scan_r_reg    <= '0;
            scan_c_reg    <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            dir_reg       <= DIR_UP;
            nb_ok_reg     <= 1'b0;
            pieces_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
                load_pos_reg <= '0;
            else if (cmd.load_we)
                load_pos_reg <= load_pos_inc;

            if (cmd.scan_start)
            begin
                scan_pos_reg <= '0;
                scan_r_reg   <= '0;
                scan_c_reg   <= '0;
                pieces_reg   <= '0;
            end
            else if (cmd.scan_adv)
            begin
                scan_pos_reg <= scan_pos_inc;
                if (({1'b0, scan_c_reg} + SIZE_W'(1)) == cols)
                begin
                    scan_c_reg <= '0;
                    scan_r_reg <= scan_r_reg + ROW_W'(1);
                end
                else
                begin
                    scan_c_reg <= scan_c_reg + COL_W'(1);
                end
            end

            if (cmd.piece_start)
            begin
                pieces_reg <= pieces_reg + COUNT_W'(1);
                head_reg   <= '0;
                tail_reg   <= POS_W'(1);
            end
            else
            begin
                if (cmd.pop_take)
                    head_reg <= head_reg + POS_W'(1);
                if (queue_we)
                    tail_reg <= tail_reg + POS_W'(1);
            end

            if (cmd.pop_take)
                dir_reg <= DIR_UP;
            else if (cmd.nb_adv)
                dir_reg <= dir_reg + 2'd1;

            if (cmd.nb_calc)
                nb_ok_reg <= nb_ok_next;

            if (cmd.result_load)
                out_valid_reg <= 1'b1;
            else if (out_taken)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.last_cell   = (load_pos_inc >= total);
    assign status.cell_bit    = cell_rd_reg;
    assign status.scan_last   = (scan_pos_inc >= total);
    assign status.queue_empty = (head_reg == tail_reg);
    assign status.nb_ok       = nb_ok_reg;
    assign status.nb_last     = (dir_reg == DIR_RIGHT);
    assign status.out_busy    = out_valid_reg;

    assign out_valid   = out_valid_reg;
    assign piece_count = out_count_reg;

endmodule

[hdl/gcc_ctrl.sv]
// ----------------------------------------------------------------------------
// gcc_ctrl
// Sequencer for load, scan and breadth-first flood fill.
// ----------------------------------------------------------------------------
module gcc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gcc_pkg::gcc_status_t status,
    output gcc_pkg::gcc_cmd_t    cmd
);
    import gcc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_POP_RD,
        ST_POP_TAKE,
        ST_NB_CALC,
        ST_NB_RD,
        ST_NB_CHK,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_we = 1'b1;
                    if (status.last_cell)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (status.cell_bit)
                begin
                    cmd.piece_start = 1'b1;
                    state_next      = ST_POP_RD;
                end
                else if (status.scan_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                    state_next   = ST_SCAN_RD;
                end
            end
            ST_POP_RD:
            begin
                if (!status.queue_empty)
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = ST_POP_TAKE;
                end
                else if (status.scan_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                    state_next   = ST_SCAN_RD;
                end
            end
            ST_POP_TAKE:
            begin
                cmd.pop_take = 1'b1;
                state_next   = ST_NB_CALC;
            end
            ST_NB_CALC:
            begin
                cmd.nb_calc = 1'b1;
                state_next  = ST_NB_RD;
            end
            ST_NB_RD:
            begin
                if (status.nb_ok)
                begin
                    cmd.nb_rd  = 1'b1;
                    state_next = ST_NB_CHK;
                end
                else if (status.nb_last)
                begin
                    state_next = ST_POP_RD;
                end
                else
                begin
                    cmd.nb_adv = 1'b1;
                    state_next = ST_NB_CALC;
                end
            end
            ST_NB_CHK:
            begin
                cmd.nb_hit = status.cell_bit;
                if (status.nb_last)
                begin
                    state_next = ST_POP_RD;
                end
                else
                begin
                    cmd.nb_adv = 1'b1;
                    state_next = ST_NB_CALC;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[hdl/grid_component_counter.sv]
// ----------------------------------------------------------------------------
// grid_component_counter
// Loads a binary grid cell by cell and reports its number of 4-connected
// pieces, optionally with the columns wrapped as on a cylinder.
// ----------------------------------------------------------------------------
//
//  Port group | Direction | Beat / transfer
//  -----------+-----------+-------------------------------------------------
//  s_axis_*   | in        | one grid cell per beat, row-major order
//  m_axis_*   | out       | one piece count per completed grid
//  APB        | in/out    | grid_rows @0x0, grid_cols @0x4, wrap_columns @0x8
//
//  While loading, a cell beat is accepted whenever one is offered. The beat
//  that completes the grid starts a scan: each cell visited by the scan is
//  read and then checked, and each filled cell is expanded by a flood-fill
//  step (queue read and take, then address calculation, cell-store read and
//  check for each neighbour). Input is held off (s_axis_tready low) during
//  scan and fill. Reset clears all control state; the stores are not cleared
//  since every cell is written before it is scanned. A result waiting on a
//  stalled m_axis side does not block the next grid's load.
//
module grid_component_counter (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // cell stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] cell_value, [7:1] zero
    // piece count out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [11:0] piece_count, [15:12] zero
);
    import gcc_pkg::*;

    gcc_cfg_t    cfg_reg;
    gcc_cmd_t    cmd;
    gcc_status_t status;
    logic        wr_en;
    logic [11:0] piece_count;

    // registers sit at word addresses; anything else is ignored
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows <= SIZE_W'(MAX_ROWS);
            cfg_reg.cols <= SIZE_W'(MAX_COLS);
            cfg_reg.wrap <= 1'b0;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                REG_ROWS: cfg_reg.rows <= pwdata[SIZE_W-1:0];
                REG_COLS: cfg_reg.cols <= pwdata[SIZE_W-1:0];
                REG_WRAP: cfg_reg.wrap <= pwdata[0];
                default:  cfg_reg      <= cfg_reg;
            endcase
        end
    end

    // read back the stored register values
    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                REG_ROWS: prdata = {{(32-SIZE_W){1'b0}}, cfg_reg.rows};
                REG_COLS: prdata = {{(32-SIZE_W){1'b0}}, cfg_reg.cols};
                REG_WRAP: prdata = {31'd0, cfg_reg.wrap};
                default:  prdata = '0;
            endcase
        end
    end

    gcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gcc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .cell_value  (s_axis_tdata[0]),
        .out_taken   (m_axis_tready),
        .status      (status),
        .out_valid   (m_axis_tvalid),
        .piece_count (piece_count)
    );

    assign m_axis_tdata = {4'd0, piece_count};

    // a new count never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> !m_axis_tvalid)
        else $error("result loaded over a pending count");

    // the output only becomes valid from a completed scan
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.result_load))
        else $error("output valid without a finished scan");

    // the beat that completes a grid stops further input
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && status.last_cell) |=> !s_axis_tready)
        else $error("input accepted during scan");

    // a flood fill never starts with work still in the queue
    a_queue_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.piece_start |-> status.queue_empty)
        else $error("flood fill started with a non-empty queue");

endmodule

[tb/sv/grid_component_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_component_checker
// Watches the register port and both streams of the grid component counter,
// keeps its own copy of the loaded grid, predicts each piece count and
// compares it with the counts that come out.
// ----------------------------------------------------------------------------
module grid_component_checker
    import gcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] cell_value, [7:1] zero
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [11:0] piece_count, [15:12] zero
    output int          fail_count,
    output int          pending_counts
);

    logic [SIZE_W-1:0]  rows_reg;
    logic [SIZE_W-1:0]  cols_reg;
    logic               wrap_reg;
    bit                 grid_cells [STORE_DEPTH];
    int                 load_pos;
    logic [COUNT_W-1:0] expected_counts [$];

    function automatic int clamp_size(logic [SIZE_W-1:0] v, int top);
        if (v == 0)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    // scan row-major, flood-fill each set cell and clear what it reaches
    function automatic logic [COUNT_W-1:0] count_pieces(int rows, int cols, bit wrap);
        int                 frontier [$];
        int                 cur;
        int                 r;
        int                 c;
        int                 nr;
        int                 nc;
        logic [COUNT_W-1:0] pieces;
        pieces = '0;
        for (int start = 0; start < rows * cols; start++)
        begin
            if (grid_cells[start])
            begin
                pieces++;
                grid_cells[start] = 1'b0;
                frontier.push_back(start);
                while (frontier.size() > 0)
                begin
                    cur = frontier.pop_front();
                    r = cur / cols;
                    c = cur % cols;
                    for (int d = 0; d < 4; d++)
                    begin
                        nr = r + ((d == DIR_UP) ? -1 : (d == DIR_DOWN) ? 1 : 0);
                        nc = c + ((d == DIR_LEFT) ? -1 : (d == DIR_RIGHT) ? 1 : 0);
                        if (wrap)
                        begin
                            if (nc < 0)
                                nc = cols - 1;
                            else if (nc >= cols)
                                nc = 0;
                        end
                        if (nr >= 0 && nr < rows && nc >= 0 && nc < cols
                            && grid_cells[nr * cols + nc])
                        begin
                            grid_cells[nr * cols + nc] = 1'b0;
                            frontier.push_back(nr * cols + nc);
                        end
                    end
                end
            end
        end
        return pieces;
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int rows;
        int cols;
        logic [COUNT_W-1:0] want;
        if (!rst_n)
        begin
            rows_reg       <= 7'd64;
            cols_reg       <= 7'd64;
            wrap_reg       <= 1'b0;
            load_pos       = 0;
            fail_count     = 0;
            pending_counts = 0;
            expected_counts.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_ROWS: rows_reg <= pwdata[SIZE_W-1:0];
                    REG_COLS: cols_reg <= pwdata[SIZE_W-1:0];
                    REG_WRAP: wrap_reg <= pwdata[0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                rows = clamp_size(rows_reg, MAX_ROWS);
                cols = clamp_size(cols_reg, MAX_COLS);
                if (load_pos < STORE_DEPTH)
                    grid_cells[load_pos] = s_axis_tdata[0];
                load_pos++;
                if (load_pos >= rows * cols)
                begin
                    expected_counts.push_back(count_pieces(rows, cols, wrap_reg));
                    load_pos = 0;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_counts.size() == 0)
                    report("unexpected piece count", m_axis_tdata, 16'd0);
                else
                begin
                    want = expected_counts.pop_front();
                    if (m_axis_tdata !== {4'b0, want})
                        report("piece_count", m_axis_tdata, {4'b0, want});
                end
            end
            pending_counts = expected_counts.size();
        end
    end

endmodule

[tb/sv/grid_component_counter_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_component_counter_test
// Drives grids of cells and register settings into the grid component
// counter under random stalls on both streams; a checker beside the block
// predicts every piece count and this top gives the verdict.
// ----------------------------------------------------------------------------
module grid_component_counter_test;
    import gcc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [0] cell_value, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [11:0] piece_count, [15:12] zero

    int fail_count;
    int pending_counts;
    int cells_sent;
    bit steady;         // high while neither side idles
    int rows_pick;
    int cols_pick;
    int density;
    int grids;

    // toggle every half period of 4 ns
    always #2 clk = ~clk;

    grid_component_counter u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    grid_component_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending_counts(pending_counts)
    );

    // stall the result side about a third of the time, never while steady
    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);

    // setup cycle, then access cycle; the register takes the value on the
    // edge where psel and penable are both high
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_grid(logic [31:0] rows, logic [31:0] cols, logic [31:0] wrap);
        reg_write(REG_ROWS, rows);
        reg_write(REG_COLS, cols);
        reg_write(REG_WRAP, wrap);
    endtask

    // one cell beat; tready is sampled at the falling edge so the decision
    // never races the block's own update at the rising edge
    task automatic send_cell(bit v);
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, v};
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
        cells_sent++;
    endtask

    // drop the last beat, hold until every expected count has been
    // delivered, then let the block settle before touching the registers
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_counts != 0);
        @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_random_grid(int cells, int fill);
        for (int i = 0; i < cells; i++)
            send_cell($urandom_range(0, 99) < fill);
    endtask

    initial
    begin
        cells_sent = 0;
        steady = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single cell, empty then filled
        set_grid(1, 1, 0);
        send_cell(1'b0);
        send_cell(1'b1);
        drain();
        // zero rows and columns act as one
        set_grid(0, 0, 1);
        send_cell(1'b1);
        drain();
        // wrapped row: the two end cells join across the edge
        set_grid(1, 6, 1);
        send_cell(1'b1); send_cell(1'b0); send_cell(1'b1);
        send_cell(1'b1); send_cell(1'b0); send_cell(1'b1);
        drain();
        // one column with wrap: a cell is its own wrapped neighbour
        set_grid(3, 1, 1);
        send_cell(1'b1); send_cell(1'b0); send_cell(1'b1);
        drain();
        // shrink the grid part way through a load: next beat starts the scan
        set_grid(3, 3, 0);
        send_cell(1'b1); send_cell(1'b0); send_cell(1'b1);
        send_cell(1'b0); send_cell(1'b1);
        drain();
        set_grid(2, 2, 0);
        send_cell(1'b1);
        drain();

        // tall grid once, with an oversized row count that clamps to 64
        set_grid(127, 4, $urandom_range(0, 1));
        send_random_grid(MAX_ROWS * 4, $urandom_range(30, 70));
        drain();

        cells_sent = 0;
        while (cells_sent < 1300)
        begin
            steady = (cells_sent >= 500 && cells_sent < 800);
            if ($urandom_range(0, 99) < 10)
            begin
                // one long edge, up to an oversized value, the other short
                rows_pick = $urandom_range(0, 127);
                cols_pick = $urandom_range(0, 4);
                if ($urandom_range(0, 1))
                begin
                    density   = rows_pick;
                    rows_pick = cols_pick;
                    cols_pick = density;
                end
            end
            else
            begin
                rows_pick = $urandom_range(1, 8);
                cols_pick = $urandom_range(1, 8);
            end
            set_grid(rows_pick, cols_pick, $urandom_range(0, 1));
            rows_pick = (rows_pick == 0) ? 1 : (rows_pick > MAX_ROWS) ? MAX_ROWS : rows_pick;
            cols_pick = (cols_pick == 0) ? 1 : (cols_pick > MAX_COLS) ? MAX_COLS : cols_pick;
            grids = $urandom_range(1, 3);
            for (int g = 0; g < grids; g++)
            begin
                density = $urandom_range(0, 100);
                send_random_grid(rows_pick * cols_pick, density);
            end
            drain();
        end
        steady = 1'b0;

        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending_counts == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // stop a hung run
    initial
    begin
        #8000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
